### sv/ppu_pkg.sv
`default_nettype none
package ppu_pkg;

  typedef enum logic [1:0] {
    OP_EMIT    = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] emit_pos_x;
    logic signed [31:0] emit_pos_y;
    logic signed [31:0] emit_vel_x;
    logic signed [31:0] emit_vel_y;
    logic [23:0]        emit_life;
    logic [7:0]         emit_size_begin;
    logic [7:0]         emit_size_end;
    logic [31:0]        emit_color;
    logic signed [31:0] emit_rotation;
    logic [15:0]        step_delta;
    logic [9:0]         read_slot;
  } in_beat_t;

  typedef struct packed {
    logic               entry_active;
    logic signed [31:0] entry_x;
    logic signed [31:0] entry_y;
    logic [7:0]         entry_size;
    logic [31:0]        entry_color;
    logic signed [31:0] entry_rotation;
    logic [9:0]         slot_written;
    logic [10:0]        live_count;
  } out_beat_t;

  // one pool entry as stored in memory
  typedef struct packed {
    logic               active;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        vel_x;
    logic [31:0]        vel_y;
    logic [31:0]        rot;
    logic [23:0]        life;
    logic signed [24:0] rem;
    logic [7:0]         size_begin;
    logic [7:0]         size_end;
    logic [7:0]         size_now;
    logic [31:0]        color;
  } entry_t;

  typedef struct packed {
    logic we;    // write back entry
    logic dec;   // entry expired, drop live count
    logic last;  // final entry of the sweep
  } wb_ctl_t;

endpackage
`default_nettype wire

### sv/ppu_if.sv
`default_nettype none
interface ppu_in_if;
  logic               valid;
  logic               ready;
  ppu_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppu_out_if;
  logic               valid;
  logic               ready;
  ppu_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/ppu_mem.sv
`default_nettype none
module ppu_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire ppu_pkg::entry_t   wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output ppu_pkg::entry_t        rdata_o
);
  import ppu_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

### sv/ppu_advance.sv
`default_nettype none
module ppu_advance #(
  parameter int unsigned AW = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_valid_i,
  input  wire logic              rd_last_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  input  wire ppu_pkg::entry_t   rd_entry_i,
  input  wire logic [15:0]       delta_i,
  output ppu_pkg::wb_ctl_t       wb_o,
  output logic [AW-1:0]          wb_addr_o,
  output ppu_pkg::entry_t        wb_entry_o
);
  import ppu_pkg::*;

  localparam int unsigned NDIV = 8;
  localparam int unsigned NST  = 3 + NDIV;

  typedef struct packed {
    logic          v;
    logic          upd;
    logic          last;
    logic          div;
    logic [AW-1:0] addr;
    entry_t        e;
  } pl_t;

  pl_t                pl_q [NST];
  pl_t                a_d, b_d, c_d;
  logic signed [48:0] prodx_q, prody_q;
  logic signed [33:0] mul1_q;
  logic [31:0]        mul2_q;
  logic [31:0]        dr_q [NDIV+1];
  logic [7:0]         dq_q [NDIV+1];
  logic [31:0]        dr_d [NDIV];
  logic [7:0]         dq_d [NDIV];
  logic [31:0]        c_r;
  logic signed [34:0] t_s;

  function automatic logic signed [8:0] diff_s_next(logic [7:0] b, logic [7:0] e);
    return $signed({1'b0, b}) - $signed({1'b0, e});
  endfunction

  // stage A: expire check, life, rotation, velocity products
  always_comb begin
    a_d      = '0;
    a_d.v    = rd_valid_i & rd_entry_i.active;
    a_d.last = rd_valid_i & rd_last_i;
    a_d.addr = rd_addr_i;
    a_d.e    = rd_entry_i;
    a_d.upd  = (rd_entry_i.rem > 25'sd0);
    if (a_d.upd) begin
      a_d.e.rem = rd_entry_i.rem - $signed({9'b0, delta_i});
      a_d.e.rot = rd_entry_i.rot + {16'b0, delta_i};
    end else begin
      a_d.e.active = 1'b0;
    end
  end

  // stage B: positions, size products
  always_comb begin
    b_d = pl_q[0];
    if (pl_q[0].upd) begin
      b_d.e.pos_x = pl_q[0].e.pos_x + prodx_q[47:16];
      b_d.e.pos_y = pl_q[0].e.pos_y + prody_q[47:16];
    end
  end

  // stage C: classify size, set up the divide
  assign t_s = $signed({3'b0, mul2_q}) + 35'(mul1_q);

  always_comb begin
    c_d     = pl_q[1];
    c_d.div = 1'b0;
    c_r     = '0;
    if (pl_q[1].upd) begin
      if (pl_q[1].e.life == 24'd0) begin
        c_d.e.size_now = pl_q[1].e.size_end;
      end else if (t_s <= 35'sd0) begin
        c_d.e.size_now = 8'd0;
      end else if (t_s >= $signed({3'b0, pl_q[1].e.life, 8'b0})) begin
        c_d.e.size_now = 8'd255;
      end else begin
        c_d.div = 1'b1;
        c_r     = t_s[31:0];
      end
    end
  end

  // restoring divide, one quotient bit per stage
  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      logic [31:0] dv;
      dv = {8'b0, pl_q[2+k].e.life} << (NDIV - 1 - k);
      dr_d[k] = dr_q[k];
      dq_d[k] = dq_q[k];
      if (dr_q[k] >= dv) begin
        dr_d[k] = dr_q[k] - dv;
        dq_d[k][NDIV-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        pl_q[k].v    <= 1'b0;
        pl_q[k].last <= 1'b0;
      end
    end else begin
      pl_q[0] <= a_d;
      pl_q[1] <= b_d;
      pl_q[2] <= c_d;
      for (int k = 0; k < NDIV; k++) begin
        pl_q[3+k] <= pl_q[2+k];
      end
    end
  end

  // size products taken from stage B so they line up with stage C
  always_ff @(posedge clk_i) begin
    prodx_q <= $signed(rd_entry_i.vel_x) * $signed({1'b0, delta_i});
    prody_q <= $signed(rd_entry_i.vel_y) * $signed({1'b0, delta_i});
    mul1_q  <= $signed(pl_q[0].e.rem) *
               diff_s_next(pl_q[0].e.size_begin, pl_q[0].e.size_end);
    mul2_q  <= {24'b0, pl_q[0].e.size_end} * {8'b0, pl_q[0].e.life};
    dr_q[0] <= c_r;
    dq_q[0] <= '0;
    for (int k = 0; k < NDIV; k++) begin
      dr_q[k+1] <= dr_d[k];
      dq_q[k+1] <= dq_d[k];
    end
  end

  always_comb begin
    wb_entry_o = pl_q[NST-1].e;
    if (pl_q[NST-1].div) begin
      wb_entry_o.size_now = dq_q[NDIV];
    end
  end

  assign wb_o.we   = pl_q[NST-1].v;
  assign wb_o.dec  = pl_q[NST-1].v & ~pl_q[NST-1].upd;
  assign wb_o.last = pl_q[NST-1].last;
  assign wb_addr_o = pl_q[NST-1].addr;
endmodule
`default_nettype wire

### sv/particle_pool_update.sv
`default_nettype none
// Emit: entry read at accept, then write back, then result load. Read and
// no-op: result load after accept. Advance: one entry per cycle through the
// single memory read port into an 11-stage update pipeline. One item in
// flight; the next beat is taken once the result is loaded.
// After reset a clearing pass zeroes the pool memory; no input beat is
// taken until it ends.
module particle_pool_update #(
  parameter int unsigned POOL_SIZE = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ppu_in_if.sink     in_i,
  ppu_out_if.source  out_o
);
  import ppu_pkg::*;

  localparam int unsigned AW = $clog2(POOL_SIZE);
  localparam int unsigned CW = $clog2(POOL_SIZE + 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EMIT  = 6'b000100,
    ST_ADV   = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] written_q, written_d;
  logic [CW-1:0] count_q, count_d;
  in_beat_t      in_q;
  logic          rd_ok_q, rd_ok_d;
  logic          out_v_q, out_v_d;
  out_beat_t     out_q, out_d;

  // memory ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  // advance pipeline feed
  logic          adv_v_q, adv_last_q;
  logic [AW-1:0] adv_addr_q;
  wb_ctl_t       wb;
  logic [AW-1:0] wb_addr;
  entry_t        wb_entry;

  logic          in_acc;
  logic          cnt_last;
  logic          out_load;
  logic [AW+9:0] rs_ext;
  logic [AW+9:0] wr_ext;
  logic [CW+10:0] cnt_ext;
  entry_t        emit_e;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign cnt_last   = (cnt_q == AW'(POOL_SIZE - 1));
  assign rs_ext     = {{AW{1'b0}}, in_i.data.read_slot};
  assign out_load   = (state_q == ST_DONE) & (~out_v_q | out_o.ready);

  // entry built from the latched emit beat; size starts at begin
  always_comb begin
    emit_e            = '0;
    emit_e.active     = 1'b1;
    emit_e.pos_x      = in_q.emit_pos_x;
    emit_e.pos_y      = in_q.emit_pos_y;
    emit_e.vel_x      = in_q.emit_vel_x;
    emit_e.vel_y      = in_q.emit_vel_y;
    emit_e.rot        = in_q.emit_rotation;
    emit_e.life       = in_q.emit_life;
    emit_e.rem        = $signed({1'b0, in_q.emit_life});
    emit_e.size_begin = in_q.emit_size_begin;
    emit_e.size_end   = in_q.emit_size_end;
    emit_e.size_now   = in_q.emit_size_begin;
    emit_e.color      = in_q.emit_color;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    written_d = written_q;
    count_d   = count_q;
    rd_ok_d   = rd_ok_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cnt_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          written_d = ptr_q;
          rd_ok_d   = (32'(in_i.data.read_slot) < POOL_SIZE);
          case (op_e'(in_i.data.operation))
            OP_EMIT: begin
              mem_re    = 1'b1;
              mem_raddr = ptr_q;
              state_d   = ST_EMIT;
            end
            OP_ADVANCE: begin
              cnt_d   = '0;
              state_d = ST_ADV;
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = rs_ext[AW-1:0];
              state_d   = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_EMIT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = emit_e;
        if (!mem_rdata.active) begin
          count_d = count_q + CW'(1);
        end
        ptr_d   = (ptr_q == '0) ? AW'(POOL_SIZE - 1) : ptr_q - AW'(1);
        state_d = ST_DONE;
      end
      ST_ADV: begin
        mem_re = 1'b1;
        cnt_d  = cnt_q + AW'(1);
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (wb.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase

    // write backs from the update pipeline
    if (wb.we) begin
      mem_we    = 1'b1;
      mem_waddr = wb_addr;
      mem_wdata = wb_entry;
    end
    if (wb.dec) begin
      count_d = count_q - CW'(1);
    end
  end

  // result beat
  assign wr_ext  = {10'b0, written_q};
  assign cnt_ext = {11'b0, count_q};

  always_comb begin
    out_d              = '0;
    out_d.slot_written = wr_ext[9:0];
    out_d.live_count   = cnt_ext[10:0];
    if ((op_e'(in_q.operation) == OP_READ) && rd_ok_q) begin
      out_d.entry_active   = mem_rdata.active;
      out_d.entry_x        = mem_rdata.pos_x;
      out_d.entry_y        = mem_rdata.pos_y;
      out_d.entry_size     = mem_rdata.size_now;
      out_d.entry_color    = mem_rdata.color;
      out_d.entry_rotation = mem_rdata.rot;
    end
    out_v_d = out_v_q;
    if (out_o.ready) begin
      out_v_d = 1'b0;
    end
    if (out_load) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      ptr_q      <= AW'(POOL_SIZE - 1);
      written_q  <= '0;
      count_q    <= '0;
      rd_ok_q    <= 1'b0;
      out_v_q    <= 1'b0;
      adv_v_q    <= 1'b0;
      adv_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ptr_q      <= ptr_d;
      written_q  <= written_d;
      count_q    <= count_d;
      rd_ok_q    <= rd_ok_d;
      out_v_q    <= out_v_d;
      adv_v_q    <= (state_q == ST_ADV);
      adv_last_q <= (state_q == ST_ADV) & cnt_last;
    end
  end

  always_ff @(posedge clk_i) begin
    adv_addr_q <= cnt_q;
    if (in_acc) begin
      in_q <= in_i.data;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  ppu_mem #(
    .DEPTH (POOL_SIZE),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ppu_advance #(
    .AW (AW)
  ) u_advance (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_valid_i (adv_v_q),
    .rd_last_i  (adv_last_q),
    .rd_addr_i  (adv_addr_q),
    .rd_entry_i (mem_rdata),
    .delta_i    (in_q.step_delta),
    .wb_o       (wb),
    .wb_addr_o  (wb_addr),
    .wb_entry_o (wb_entry)
  );

  // write backs only while an advance sweep is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb.we |-> (state_q == ST_ADV || state_q == ST_DRAIN))
    else $error("write back outside advance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= POOL_SIZE)
    else $error("live count above pool size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb.dec |-> (count_q != '0))
    else $error("live count underflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op_e'(in_i.data.operation) == OP_EMIT)) |=> (state_q == ST_EMIT))
    else $error("emit did not enter write back");

endmodule
`default_nettype wire

### bench/tb_particle_pool_update.sv
`timescale 1ns / 1ps
module tb_particle_pool_update;
  import ppu_pkg::*;

  localparam int unsigned POOL  = 1024;
  localparam int unsigned IDLE_PCT = 34;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppu_in_if  in_i ();
  ppu_out_if out_o ();

  particle_pool_update #(.POOL_SIZE(POOL)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the particle pool
  logic        pool_act [POOL];
  logic [31:0] pool_px  [POOL];
  logic [31:0] pool_py  [POOL];
  logic [31:0] pool_vx  [POOL];
  logic [31:0] pool_vy  [POOL];
  logic [31:0] pool_rot [POOL];
  logic [23:0] pool_life[POOL];
  int          pool_rem [POOL];
  logic [7:0]  pool_beg [POOL];
  logic [7:0]  pool_end [POOL];
  logic [7:0]  pool_size[POOL];
  logic [31:0] pool_col [POOL];
  bit          pool_wr  [POOL];
  int          wr_slots[$];
  int unsigned slot_ptr;
  int unsigned live_total;

  out_beat_t   pending_results[$];
  int          fail_count = 0;
  bit          calm = 1'b0;
  int          hold_cycles = 0;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t res;
  } row_t;
  row_t rows[$];

  function automatic logic [31:0] move_pos(logic [31:0] pos, logic [31:0] vel,
                                           logic [15:0] dt);
    longint prod;
    prod = longint'($signed(vel)) * longint'({1'b0, dt});
    return pos + 32'(prod >>> 16);   // floor division by 2^16
  endfunction

  function automatic logic [7:0] cur_size(int i);
    longint lf, bg, en, t;
    lf = pool_life[i];
    bg = pool_beg[i];
    en = pool_end[i];
    if (lf == 0) return pool_end[i];
    t = en * lf + longint'(pool_rem[i]) * (bg - en);
    if (t <= 0) return 8'd0;
    t = t / lf;
    return (t > 255) ? 8'd255 : 8'(t);
  endfunction

  // applies one beat to the shadow pool, returns the result beat it gives
  function automatic out_beat_t pool_apply(in_beat_t b);
    out_beat_t r;
    int unsigned s;
    r = '0;
    r.slot_written = 10'(slot_ptr);
    case (op_e'(b.operation))
      OP_EMIT: begin
        s = slot_ptr;
        if (!pool_act[s]) live_total++;
        if (!pool_wr[s]) wr_slots.push_back(s);
        pool_wr[s]   = 1'b1;
        pool_act[s]  = 1'b1;
        pool_px[s]   = b.emit_pos_x;
        pool_py[s]   = b.emit_pos_y;
        pool_vx[s]   = b.emit_vel_x;
        pool_vy[s]   = b.emit_vel_y;
        pool_life[s] = b.emit_life;
        pool_rem[s]  = int'(b.emit_life);
        pool_beg[s]  = b.emit_size_begin;
        pool_end[s]  = b.emit_size_end;
        pool_size[s] = b.emit_size_begin;
        pool_col[s]  = b.emit_color;
        pool_rot[s]  = b.emit_rotation;
        slot_ptr = (s == 0) ? POOL - 1 : s - 1;
      end
      OP_ADVANCE: begin
        for (int i = 0; i < POOL; i++) begin
          if (!pool_act[i]) continue;
          if (pool_rem[i] <= 0) begin
            pool_act[i] = 1'b0;
            live_total--;
            continue;
          end
          pool_rem[i]  = pool_rem[i] - int'(b.step_delta);
          pool_px[i]   = move_pos(pool_px[i], pool_vx[i], b.step_delta);
          pool_py[i]   = move_pos(pool_py[i], pool_vy[i], b.step_delta);
          pool_rot[i]  = pool_rot[i] + 32'(b.step_delta);
          pool_size[i] = cur_size(i);
        end
      end
      OP_READ: begin
        s = b.read_slot;
        r.entry_active   = pool_act[s];
        r.entry_x        = pool_px[s];
        r.entry_y        = pool_py[s];
        r.entry_size     = pool_size[s];
        r.entry_color    = pool_col[s];
        r.entry_rotation = pool_rot[s];
      end
      default: ;
    endcase
    r.live_count = 11'(live_total);
    return r;
  endfunction

  function automatic in_beat_t emit_beat(logic [31:0] px, logic [31:0] py,
                                         logic [31:0] vx, logic [31:0] vy,
                                         logic [23:0] life, logic [7:0] bg,
                                         logic [7:0] en, logic [31:0] col,
                                         logic [31:0] rot);
    in_beat_t b;
    b = '0;
    b.operation = OP_EMIT;
    b.emit_pos_x = px; b.emit_pos_y = py;
    b.emit_vel_x = vx; b.emit_vel_y = vy;
    b.emit_life = life;
    b.emit_size_begin = bg; b.emit_size_end = en;
    b.emit_color = col; b.emit_rotation = rot;
    return b;
  endfunction

  function automatic in_beat_t ctl_beat(op_e op, logic [15:0] dt, logic [9:0] slot);
    in_beat_t b;
    b = '0;
    b.operation = op;
    b.step_delta = dt;
    b.read_slot = slot;
    return b;
  endfunction

  function automatic out_beat_t res_of(logic act, logic [31:0] x, logic [31:0] y,
                                       logic [7:0] sz, logic [31:0] col,
                                       logic [31:0] rot, logic [9:0] slot,
                                       logic [10:0] live);
    out_beat_t r;
    r.entry_active = act; r.entry_x = x; r.entry_y = y; r.entry_size = sz;
    r.entry_color = col; r.entry_rotation = rot;
    r.slot_written = slot; r.live_count = live;
    return r;
  endfunction

  function automatic void add_row(in_beat_t b, bit typed = 1'b0, out_beat_t r = '0);
    row_t rw;
    rw.beat = b; rw.typed = typed; rw.res = r;
    rows.push_back(rw);
  endfunction

  // random emit: mostly short lives so entries expire during the run
  function automatic in_beat_t rand_emit();
    logic [23:0] life;
    case ($urandom_range(9))
      0:       life = 24'($urandom) | 24'd1;
      1:       life = 24'($urandom_range(1, 16));
      default: life = 24'($urandom_range(1, 24'h4_0000));
    endcase
    return emit_beat($urandom, $urandom, $urandom, $urandom, life,
                     8'($urandom), 8'($urandom), $urandom, $urandom);
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      b = rand_emit();
    end else if (pick < 62) begin
      b = ctl_beat(OP_ADVANCE, ($urandom_range(3) == 0) ? 16'($urandom_range(15))
                                                        : 16'($urandom), '0);
    end else if (pick < 95 && wr_slots.size() > 0) begin
      // reads only hit entries already written
      b = ctl_beat(OP_READ, 16'($urandom), 10'(wr_slots[$urandom_range(wr_slots.size() - 1)]));
    end else begin
      b = ctl_beat(OP_NOP, 16'($urandom), 10'($urandom));
    end
    // payload of unused fields is don't-care; toggle it too
    if (b.operation != OP_EMIT) begin
      b.emit_pos_x = $urandom; b.emit_color = $urandom; b.emit_rotation = $urandom;
    end
    if (b.operation != OP_READ) b.read_slot = 10'($urandom);
    return b;
  endfunction

  // drives one beat, records its expected result once it is taken
  task automatic send_beat(in_beat_t b, bit typed, out_beat_t r);
    out_beat_t model_res;
    in_i.valid <= 1'b1;
    in_i.data  <= b;
    do @(posedge clk_i); while (!in_i.ready);
    model_res = pool_apply(b);
    pending_results.push_back(typed ? r : model_res);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_i.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // sink side: random back-pressure plus result checking
  initial begin
    out_o.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_o.valid && out_o.ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          out_beat_t e;
          out_beat_t a;
          e = pending_results.pop_front();
          a = out_o.data;
          if (a.entry_active !== e.entry_active) begin
            $error("entry_active exp %0d got %0d", e.entry_active, a.entry_active); fail_count++;
          end
          if (a.entry_x !== e.entry_x) begin
            $error("entry_x exp %h got %h", e.entry_x, a.entry_x); fail_count++;
          end
          if (a.entry_y !== e.entry_y) begin
            $error("entry_y exp %h got %h", e.entry_y, a.entry_y); fail_count++;
          end
          if (a.entry_size !== e.entry_size) begin
            $error("entry_size exp %0d got %0d", e.entry_size, a.entry_size); fail_count++;
          end
          if (a.entry_color !== e.entry_color) begin
            $error("entry_color exp %h got %h", e.entry_color, a.entry_color); fail_count++;
          end
          if (a.entry_rotation !== e.entry_rotation) begin
            $error("entry_rotation exp %h got %h", e.entry_rotation, a.entry_rotation);
            fail_count++;
          end
          if (a.slot_written !== e.slot_written) begin
            $error("slot_written exp %0d got %0d", e.slot_written, a.slot_written); fail_count++;
          end
          if (a.live_count !== e.live_count) begin
            $error("live_count exp %0d got %0d", e.live_count, a.live_count); fail_count++;
          end
        end
      end
      if (!rst_ni) out_o.ready <= 1'b0;
      else if (hold_cycles > 0) begin
        hold_cycles--;
        out_o.ready <= 1'b0;
      end else out_o.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #40ms;
    $display("tb_particle_pool_update: FAIL");
    $finish;
  end

  initial begin
    in_i.valid = 1'b0;
    in_i.data  = '0;
    for (int i = 0; i < POOL; i++) begin
      pool_act[i] = 1'b0; pool_wr[i] = 1'b0;
    end
    slot_ptr = POOL - 1;
    live_total = 0;

    // directed rows; typed results only where obvious
    add_row(ctl_beat(OP_NOP, 16'hFFFF, 10'h3FF), 1'b1,
            res_of(1'b0, '0, '0, '0, '0, '0, 10'd1023, 11'd0));
    add_row(emit_beat(32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                      24'hFF_FFFF, 8'd255, 8'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF), 1'b1,
            res_of(1'b0, '0, '0, '0, '0, '0, 10'd1023, 11'd1));
    add_row(ctl_beat(OP_READ, '0, 10'd1023), 1'b1,
            res_of(1'b1, 32'h7FFF_FFFF, 32'h0001_0000, 8'd255, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 10'd1022, 11'd1));
    add_row(emit_beat(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      24'd1, 8'd0, 8'd255, 32'h0, 32'h8000_0000));
    // zero life: the entry expires at the first advance, size stays at the begin value
    add_row(emit_beat(32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000,
                      24'd0, 8'd10, 8'd200, 32'h1234_5678, 32'h0));
    add_row(emit_beat(32'h100, 32'h200, 32'hFFFF_8000, 32'h0003_0000,
                      24'h02_0000, 8'd100, 8'd20, 32'hA5A5_5A5A, 32'h1));
    add_row(ctl_beat(OP_ADVANCE, 16'hFFFF, 10'h155));
    for (int s = 1020; s < 1024; s++) add_row(ctl_beat(OP_READ, '0, 10'(s)));
    add_row(ctl_beat(OP_ADVANCE, 16'h0, 10'h2AA));
    add_row(ctl_beat(OP_ADVANCE, 16'h8000, '0));
    add_row(ctl_beat(OP_ADVANCE, 16'h0001, '0));
    for (int s = 1020; s < 1024; s++) add_row(ctl_beat(OP_READ, '0, 10'(s)));
    add_row(ctl_beat(OP_NOP, '0, '0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[k]) send_beat(rows[k].beat, rows[k].typed, rows[k].res);

    // random traffic, with a calm stretch in the middle
    for (int n = 0; n < 560; n++) begin
      calm = (n >= 200 && n < 260);
      if (n == 120) hold_cycles = 3000;   // sink stalls long, source keeps offering
      if (n == 300) begin
        in_i.valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk_i);
      end
      send_beat(rand_beat(), 1'b0, '0);
    end
    in_i.valid <= 1'b0;
    calm = 1'b0;

    wait (pending_results.size() == 0);
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) $display("tb_particle_pool_update: PASS");
    else $display("tb_particle_pool_update: FAIL");
    $finish;
  end

endmodule
